>>> sv/s1h_pkg.sv
// shared constants and round helpers for the sha-1 byte stream hasher
// no dependencies
package s1h_pkg;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int unsigned NUM_ROUNDS = 80;
    localparam int unsigned NUM_WORDS = 5;

    // compression controls from the sequencer to the core
    typedef struct packed {
        logic init;   // copy hash into working registers
        logic load;   // shift one block word into the schedule
        logic round;  // run one round
        logic add;    // fold working registers into hash
        logic clear;  // back to the initial hash
    } s1h_ctl_t;

    function automatic logic [31:0] s1h_f(input logic [6:0] t, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
        logic [31:0] r;
        if (t < 7'd20) begin
            r = (b & c) | (~b & d);
        end else if (t >= 7'd40 && t < 7'd60) begin
            r = (b & c) | (b & d) | (c & d);
        end else begin
            r = b ^ c ^ d;
        end
        return r;
    endfunction

    function automatic logic [31:0] s1h_k(input logic [6:0] t);
        logic [31:0] r;
        if (t < 7'd20) begin
            r = K0;
        end else if (t < 7'd40) begin
            r = K1;
        end else if (t < 7'd60) begin
            r = K2;
        end else begin
            r = K3;
        end
        return r;
    endfunction

endpackage

>>> sv/sha1_byte_stream_hasher.sv
// top level of the sha-1 byte stream hasher: sequencer, padding, length, output
// depends on s1h_pkg, s1h_buf, s1h_core
//
// Takes one item per handshake; an item may carry a message byte and may end the message.
// A byte that completes a 64-byte block starts a compression: the block streams out of the
// buffer memory into the schedule window, then one round per cycle, then the hash update;
// no item is taken until it is done. An end of message runs one padded block (two when 56
// or more bytes are pending), then shows the five digest words, one per output handshake,
// word 0 first. The sustained rate is set by the single round unit. Padding is muxed into
// the words as they leave the buffer, so the buffer is never swept. A message over
// 2^64 - 1 bits gives five words of zero with status 1. After the last word the block is
// ready for a new message.
module sha1_byte_stream_hasher
    import s1h_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_has_byte,
    input  logic        s_end_of_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word,
    output logic        m_status
);

    typedef enum logic [2:0] {ST_IDLE, ST_LOAD, ST_ROUND, ST_ADD, ST_EMIT} state_t;
    // which flavor of block is being compressed
    typedef enum logic [1:0] {KIND_NORM, KIND_FIN_A, KIND_FIN_B} kind_t;

    state_t      state_reg, state_next;
    kind_t       kind_reg, kind_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] len_reg, len_next;
    logic        ovf_reg, ovf_next;
    logic        endp_reg, endp_next;
    logic [2:0]  idx_reg, idx_next;
    logic [3:0]  rdidx_reg;

    logic        in_acc, byte_ok;
    logic [63:0] len_inc;
    logic [31:0] rd_data, hash_word, load_word;
    s1h_ctl_t    ctl;

    assign s_ready = (state_reg == ST_IDLE);
    assign in_acc  = s_valid && s_ready;
    assign byte_ok = in_acc && s_has_byte && !ovf_reg;
    assign len_inc = len_reg + 64'd8;

    s1h_buf u_buf (
        .aclk    (aclk),
        .wr_en   (byte_ok),
        .wr_addr (fill_reg),
        .wr_data (s_data_byte),
        .rd_addr (cnt_reg[3:0]),
        .rd_data (rd_data)
    );

    // padding mux: each lane picks buffer data, the marker byte, a length byte or zero
    always_comb begin
        logic [5:0] p;
        logic [2:0] ls;
        logic [7:0] mb, lb, ob;
        for (int j = 0; j < 4; j++) begin
            p  = {rdidx_reg, 2'(j)};
            ls = 3'd7 - p[2:0];
            mb = rd_data[8 * (3 - j) +: 8];
            lb = len_reg[{ls, 3'b000} +: 8];
            case (kind_reg)
                KIND_NORM: ob = mb;
                KIND_FIN_A: begin
                    if (p < fill_reg) begin
                        ob = mb;
                    end else if (p == fill_reg) begin
                        ob = PAD_BYTE;
                    end else if (p[5:3] == 3'b111 && fill_reg[5:3] != 3'b111) begin
                        ob = lb;
                    end else begin
                        ob = 8'h00;
                    end
                end
                KIND_FIN_B: ob = (p[5:3] == 3'b111) ? lb : 8'h00;
                default:    ob = 8'h00;
            endcase
            load_word[8 * (3 - j) +: 8] = ob;
        end
    end

    always_comb begin
        ctl       = '0;
        ctl.init  = (state_reg == ST_LOAD) && (cnt_reg == 7'd0);
        ctl.load  = (state_reg == ST_LOAD) && (cnt_reg != 7'd0);
        ctl.round = (state_reg == ST_ROUND);
        ctl.add   = (state_reg == ST_ADD);
        ctl.clear = (state_reg == ST_EMIT) && m_ready && (idx_reg == 3'(NUM_WORDS - 1));
    end

    s1h_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .load_word (load_word),
        .round_idx (cnt_reg),
        .sel       (idx_reg),
        .hash_word (hash_word)
    );

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cnt_next   = cnt_reg;
        fill_next  = fill_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        endp_next  = endp_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    endp_next = s_end_of_message;
                    cnt_next  = 7'd0;
                    idx_next  = 3'd0;
                    if (byte_ok) begin
                        fill_next = fill_reg + 6'd1;
                        len_next  = len_inc;
                        if (len_inc == 64'd0) begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (byte_ok && fill_reg == 6'd63) begin
                        state_next = ST_LOAD;
                        kind_next  = KIND_NORM;
                    end else if (s_end_of_message) begin
                        if (ovf_next) begin
                            state_next = ST_EMIT;
                        end else begin
                            state_next = ST_LOAD;
                            kind_next  = KIND_FIN_A;
                        end
                    end
                end
            end
            ST_LOAD: begin
                if (cnt_reg == 7'd16) begin
                    state_next = ST_ROUND;
                    cnt_next   = 7'd0;
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_ROUND: begin
                if (cnt_reg == 7'(NUM_ROUNDS - 1)) begin
                    state_next = ST_ADD;
                end
                cnt_next = cnt_reg + 7'd1;
            end
            ST_ADD: begin
                cnt_next = 7'd0;
                case (kind_reg)
                    KIND_NORM: begin
                        if (!endp_reg) begin
                            state_next = ST_IDLE;
                        end else if (ovf_reg) begin
                            state_next = ST_EMIT;
                        end else begin
                            state_next = ST_LOAD;
                            kind_next  = KIND_FIN_A;
                        end
                    end
                    KIND_FIN_A: begin
                        // no room for the length field: one more block
                        if (fill_reg[5:3] == 3'b111) begin
                            state_next = ST_LOAD;
                            kind_next  = KIND_FIN_B;
                        end else begin
                            state_next = ST_EMIT;
                        end
                    end
                    default: state_next = ST_EMIT;
                endcase
            end
            ST_EMIT: begin
                if (m_ready) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'(NUM_WORDS - 1)) begin
                        state_next = ST_IDLE;
                        fill_next  = 6'd0;
                        len_next   = 64'd0;
                        ovf_next   = 1'b0;
                        endp_next  = 1'b0;
                        idx_next   = 3'd0;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            kind_reg  <= KIND_NORM;
            cnt_reg   <= 7'd0;
            fill_reg  <= 6'd0;
            len_reg   <= 64'd0;
            ovf_reg   <= 1'b0;
            endp_reg  <= 1'b0;
            idx_reg   <= 3'd0;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            cnt_reg   <= cnt_next;
            fill_reg  <= fill_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            endp_reg  <= endp_next;
            idx_reg   <= idx_next;
        end
    end

    // word index of the data coming out of the buffer this cycle
    always_ff @(posedge aclk) begin
        rdidx_reg <= cnt_reg[3:0];
    end

    assign m_valid       = (state_reg == ST_EMIT);
    assign m_word_index  = idx_reg;
    assign m_last_word   = (idx_reg == 3'(NUM_WORDS - 1));
    assign m_status      = ovf_reg;
    assign m_digest_word = ovf_reg ? 32'd0 : hash_word;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while digest words pending");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_word_index <= 3'd4))
        else $error("digest word index out of range");

    a_back_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_word) |=> (s_ready && fill_reg == 6'd0 && !ovf_reg))
        else $error("state not cleared after last digest word");

    a_ovf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_digest_word == 32'd0))
        else $error("overflowed message gives nonzero word");

endmodule

>>> sv/s1h_buf.sv
// 64-byte block buffer, byte writes, registered word reads
// depends on s1h_pkg
module s1h_buf
    import s1h_pkg::*;
(
    input  logic        aclk,
    input  logic        wr_en,
    input  logic [5:0]  wr_addr,
    input  logic [7:0]  wr_data,
    input  logic [3:0]  rd_addr,
    output logic [31:0] rd_data
);

    logic [3:0][7:0] mem [16];

    // byte 0 of a word sits in the top lane
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr[5:2]][~wr_addr[1:0]] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> sv/s1h_core.sv
// sha-1 compression core: schedule window, working registers, hash registers
// depends on s1h_pkg
module s1h_core
    import s1h_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  s1h_ctl_t    ctl,
    input  logic [31:0] load_word,
    input  logic [6:0]  round_idx,
    input  logic [2:0]  sel,
    output logic [31:0] hash_word
);

    logic [31:0] w_reg [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] h_reg [NUM_WORDS];
    logic [31:0] w_new, w_cur, temp;

    always_comb begin
        w_new = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        w_new = {w_new[30:0], w_new[31]};
        w_cur = (round_idx < 7'd16) ? w_reg[0] : w_new;
        temp  = {a_reg[26:0], a_reg[31:27]} + s1h_f(round_idx, b_reg, c_reg, d_reg)
              + e_reg + w_cur + s1h_k(round_idx);
    end

    always_ff @(posedge aclk) begin
        if (ctl.load || ctl.round) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= ctl.load ? load_word : w_cur;
        end
        if (ctl.init) begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end else if (ctl.round) begin
            a_reg <= temp;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            h_reg[0] <= IV0;
            h_reg[1] <= IV1;
            h_reg[2] <= IV2;
            h_reg[3] <= IV3;
            h_reg[4] <= IV4;
        end else if (ctl.add) begin
            h_reg[0] <= h_reg[0] + a_reg;
            h_reg[1] <= h_reg[1] + b_reg;
            h_reg[2] <= h_reg[2] + c_reg;
            h_reg[3] <= h_reg[3] + d_reg;
            h_reg[4] <= h_reg[4] + e_reg;
        end
    end

    always_comb begin
        case (sel)
            3'd0:    hash_word = h_reg[0];
            3'd1:    hash_word = h_reg[1];
            3'd2:    hash_word = h_reg[2];
            3'd3:    hash_word = h_reg[3];
            default: hash_word = h_reg[4];
        endcase
    end

endmodule
